### hw/rtl/rhe_pkg.sv
package rhe_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    localparam int QUO_BITS = 8;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_out_req;

    typedef struct packed {
        logic clr;
        logic cnt_rd;
        logic cnt_we;
        logic bld_rd;
        logic cdf_clr;
        logic cdf_acc;
        logic div_start;
        logic div_step;
        logic tbl_we;
        logic map_rd;
    } t_lane_ctl;

endpackage

### hw/rtl/rhe_lane.sv
module rhe_lane #(
    parameter int LEVELS = 256,
    parameter int CW     = 21
) (
    input  logic                      i_clk,
    input  rhe_pkg::t_lane_ctl        i_ctl,
    input  logic [$clog2(LEVELS)-1:0] i_addr,
    input  logic [CW-1:0]             i_total,
    output logic [7:0]                o_tbl
);

    localparam int NW = CW + rhe_pkg::QUO_BITS;

    logic [CW-1:0] r_bins [LEVELS];
    logic [7:0]    r_tbl  [LEVELS];
    logic [CW-1:0] r_bin_rd;
    logic [7:0]    r_tbl_rd;
    logic [CW-1:0] r_cdf;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dv;
    logic [7:0]    r_quo;
    logic          ge;

    assign ge    = (r_rem >= r_dv);
    assign o_tbl = r_tbl_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_bins[i_addr] <= '0;
        end else if (i_ctl.cnt_we) begin
            r_bins[i_addr] <= r_bin_rd + CW'(1);
        end
        if (i_ctl.cnt_rd || i_ctl.bld_rd) begin
            r_bin_rd <= r_bins[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_tbl[i_addr] <= '0;
        end else if (i_ctl.tbl_we) begin
            r_tbl[i_addr] <= (i_total == '0) ? 8'd0 : r_quo;
        end
        if (i_ctl.map_rd) begin
            r_tbl_rd <= r_tbl[i_addr];
        end
    end

    // running sum and restoring divide of 255*cdf by the pixel total
    always_ff @(posedge i_clk) begin
        if (i_ctl.cdf_clr) begin
            r_cdf <= '0;
        end else if (i_ctl.cdf_acc) begin
            r_cdf <= r_cdf + r_bin_rd;
        end
        if (i_ctl.div_start) begin
            r_rem <= NW'({r_cdf, 8'd0}) - NW'(r_cdf);
            r_dv  <= NW'({i_total, 7'd0});
            r_quo <= '0;
        end else if (i_ctl.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dv;
            end
            r_dv  <= r_dv >> 1;
            r_quo <= {r_quo[6:0], ge};
        end
    end

endmodule

### hw/rtl/rgb_histogram_equalizer_unit.sv
// Count request: bin read on accept, incremented bin written in S_CNT. Map request with
// current tables: table read in S_MAP, result registered from S_OUT; a map waits while
// the result register is full and stalled. First map after reset or counting rebuilds the
// tables level by level (bin read, accumulate, divider start, 8-step divider, table write).
// Reset and each clear request run a clearing pass over the bin and table memories;
// no request is taken during the pass.
module rgb_histogram_equalizer_unit #(
    parameter int MAX_PIXELS = 1048576,
    parameter int LEVELS     = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rhe_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rhe_pkg::t_out_req o_out_data
);

    localparam int IW = $clog2(LEVELS);
    localparam int CW = $clog2(MAX_PIXELS + 1);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_CNT    = 10'b0000000100,
        S_MAP    = 10'b0000001000,
        S_BRD    = 10'b0000010000,
        S_BACC   = 10'b0000100000,
        S_BSTART = 10'b0001000000,
        S_BDIV   = 10'b0010000000,
        S_BWR    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_lvl, n_lvl;
    logic [2:0]         r_step, n_step;
    logic [CW-1:0]      r_total, n_total;
    logic               r_fresh, n_fresh;
    logic               r_out_valid;
    rhe_pkg::t_out_req  r_out;
    logic [IW-1:0]      r_pix [3];
    logic [IW-1:0]      in_idx [3];
    logic [IW-1:0]      lane_addr [3];
    logic [7:0]         lane_tbl [3];
    logic [7:0]         in_val [3];
    rhe_pkg::t_lane_ctl ctl;
    logic               accept;
    logic               out_free;
    logic               lvl_last;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign lvl_last   = (r_lvl == IW'(LEVELS - 1));
    assign in_val[0]  = i_in_data.red_in;
    assign in_val[1]  = i_in_data.green_in;
    assign in_val[2]  = i_in_data.blue_in;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (32'(in_val[k]) >= LEVELS) begin
                in_idx[k] = IW'(LEVELS - 1);
            end else begin
                in_idx[k] = IW'(in_val[k]);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_step  = r_step;
        n_total = r_total;
        n_fresh = r_fresh;
        ctl     = '0;
        case (r_state)
            S_CLEAR: begin
                ctl.clr = 1'b1;
                n_lvl   = r_lvl + IW'(1);
                if (lvl_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.command)
                        rhe_pkg::CMD_CLEAR: begin
                            n_state = S_CLEAR;
                            n_lvl   = '0;
                            n_total = '0;
                            n_fresh = 1'b1;
                        end
                        rhe_pkg::CMD_COUNT: begin
                            if (r_total < CW'(MAX_PIXELS)) begin
                                ctl.cnt_rd = 1'b1;
                                n_state    = S_CNT;
                                n_total    = r_total + CW'(1);
                                n_fresh    = 1'b0;
                            end
                        end
                        rhe_pkg::CMD_MAP: begin
                            n_state = S_MAP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CNT: begin
                ctl.cnt_we = 1'b1;
                n_state    = S_IDLE;
            end
            S_MAP: begin
                if (r_fresh) begin
                    ctl.map_rd = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    ctl.cdf_clr = 1'b1;
                    n_lvl       = '0;
                    n_state     = S_BRD;
                end
            end
            S_BRD: begin
                ctl.bld_rd = 1'b1;
                n_state    = S_BACC;
            end
            S_BACC: begin
                ctl.cdf_acc = 1'b1;
                n_state     = S_BSTART;
            end
            S_BSTART: begin
                ctl.div_start = 1'b1;
                n_step        = '0;
                n_state       = S_BDIV;
            end
            S_BDIV: begin
                ctl.div_step = 1'b1;
                n_step       = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = S_BWR;
                end
            end
            S_BWR: begin
                ctl.tbl_we = 1'b1;
                n_lvl      = r_lvl + IW'(1);
                if (lvl_last) begin
                    n_fresh = 1'b1;
                    n_state = S_MAP;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_IDLE) begin
                lane_addr[k] = in_idx[k];
            end else if (r_state == S_CNT || r_state == S_MAP) begin
                lane_addr[k] = r_pix[k];
            end else begin
                lane_addr[k] = r_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_lvl   <= '0;
            r_step  <= '0;
            r_total <= '0;
            r_fresh <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_step  <= n_step;
            r_total <= n_total;
            r_fresh <= n_fresh;
        end
    end

    // hold the pixel across count, map and table build
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                r_pix[k] <= in_idx[k];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rhe_lane #(
            .LEVELS (LEVELS),
            .CW     (CW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_addr  (lane_addr[g]),
            .i_total (r_total),
            .o_tbl   (lane_tbl[g])
        );
    end

    // merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.red_out   <= lane_tbl[0];
            r_out.green_out <= lane_tbl[1];
            r_out.blue_out  <= lane_tbl[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_from_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result shown without map request");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_PIXELS))
        else $error("pixel total beyond limit");

    a_clear_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.command == rhe_pkg::CMD_CLEAR)
            |=> (r_fresh && r_total == '0 && r_state == S_CLEAR))
        else $error("clear request did not reset state");

endmodule
